// ===== hdl/lcdws_pkg.sv =====
`default_nettype none

package lcdws_pkg;

   localparam int MAX_DIGITS  = 16;
   localparam int NUM_BITS    = 16;
   localparam int BCD_DIGITS  = 5;
   localparam int BCD_W       = 4 * BCD_DIGITS;
   localparam int BIT_CNT_W   = $clog2(NUM_BITS);
   localparam int STEP_W      = $clog2(MAX_DIGITS + 2);
   localparam int DIGIT_IDX_W = $clog2(BCD_DIGITS);
   localparam int INIT_WRITES = 4;

   typedef enum logic [1:0] {
      ACT_INIT   = 2'd0,
      ACT_CHAR   = 2'd1,
      ACT_NUMBER = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   localparam logic [1:0] TOP_LINE = 2'd1;

   localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;
   localparam logic [7:0] LINE2_OFFSET     = 8'h40;
   localparam logic [7:0] ASCII_ZERO       = 8'h30;

   typedef struct packed {
      logic load;
      logic conv;
      logic advance;
   } dp_cmd_type;

   typedef struct packed {
      logic conv_done;
      logic last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hdl/lcdws_ctrl.sv =====
`default_nettype none

module lcdws_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic [1:0]               req_action,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output lcdws_pkg::dp_cmd_type         cmd,
   input  wire lcdws_pkg::dp_status_type status
);
   import lcdws_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_SEND = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (req_action) inside
                  ACT_INIT, ACT_CHAR: state_in = ST_SEND;
                  ACT_NUMBER:         state_in = ST_CONV;
                  default:            state_in = ST_IDLE;
               endcase
            end
         end
         ST_CONV: begin
            cmd.conv = 1'b1;
            if (status.conv_done) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/lcdws_dp.sv =====
`default_nettype none

module lcdws_dp (
   input  wire logic                 clock,
   input  wire lcdws_pkg::dp_cmd_type cmd,
   output lcdws_pkg::dp_status_type  status,
   input  wire logic [1:0]           req_action,
   input  wire logic [1:0]           req_line,
   input  wire logic [4:0]           req_column,
   input  wire logic [7:0]           req_char_code,
   input  wire logic [15:0]          req_number,
   input  wire logic [4:0]           req_digit_count,
   output logic                      rsp_is_data,
   output logic [7:0]                rsp_bus_byte,
   output logic                      rsp_last
);
   import lcdws_pkg::*;

   action_type                         action_ff, action_in;
   logic [1:0]                         line_ff, line_in;
   logic [4:0]                         column_ff, column_in;
   logic [7:0]                         char_ff, char_in;
   logic [NUM_BITS-1:0]                num_sh_ff, num_sh_in;
   logic [STEP_W-1:0]                  count_ff, count_in;
   logic [STEP_W-1:0]                  step_ff, step_in;
   logic [BIT_CNT_W-1:0]               bit_cnt_ff, bit_cnt_in;
   logic [BCD_DIGITS-1:0][3:0]         bcd_ff, bcd_in;
   logic [BCD_DIGITS-1:0][3:0]         bcd_adj;
   logic [BCD_W-1:0]                   bcd_flat;

   logic [7:0]        col_m1;
   logic [7:0]        cursor;
   logic [STEP_W-1:0] digit_pos;
   logic [3:0]        digit;

   // double dabble: add-3 correction then shift in one number bit per cycle
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      bcd_flat = bcd_adj;
   end

   always_comb begin
      action_in  = action_ff;
      line_in    = line_ff;
      column_in  = column_ff;
      char_in    = char_ff;
      num_sh_in  = num_sh_ff;
      count_in   = count_ff;
      step_in    = step_ff;
      bit_cnt_in = bit_cnt_ff;
      bcd_in     = bcd_ff;
      if (cmd.load) begin
         action_in  = action_type'(req_action);
         line_in    = req_line;
         column_in  = req_column;
         char_in    = req_char_code;
         num_sh_in  = req_number;
         count_in   = (req_digit_count > 5'(MAX_DIGITS)) ? STEP_W'(MAX_DIGITS)
                                                         : STEP_W'(req_digit_count);
         step_in    = '0;
         bit_cnt_in = '0;
         bcd_in     = '0;
      end else if (cmd.conv) begin
         bcd_in     = {bcd_flat[BCD_W-2:0], num_sh_ff[NUM_BITS-1]};
         num_sh_in  = {num_sh_ff[NUM_BITS-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + 1'b1;
      end else if (cmd.advance) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      line_ff    <= line_in;
      column_ff  <= column_in;
      char_ff    <= char_in;
      num_sh_ff  <= num_sh_in;
      count_ff   <= count_in;
      step_ff    <= step_in;
      bit_cnt_ff <= bit_cnt_in;
      bcd_ff     <= bcd_in;
   end

   assign status.conv_done = (bit_cnt_ff == BIT_CNT_W'(NUM_BITS - 1));

   // column wraps through 8 bits, second line sits at offset 0x40
   always_comb begin
      col_m1 = {3'b000, column_ff} - 8'd1;
      cursor = CMD_SET_DDRAM | ((line_ff == TOP_LINE) ? col_m1 : col_m1 + LINE2_OFFSET);
   end

   // digit of weight 10^pos, positions beyond the bcd register read as zero
   always_comb begin
      digit_pos = count_ff - step_ff;
      digit     = 4'd0;
      if (digit_pos < STEP_W'(BCD_DIGITS)) begin
         digit = bcd_ff[digit_pos[DIGIT_IDX_W-1:0]];
      end
   end

   always_comb begin
      rsp_is_data  = 1'b0;
      rsp_bus_byte = 8'h00;
      rsp_last     = 1'b0;
      unique case (action_ff)
         ACT_INIT: begin
            case (step_ff[1:0])
               2'd0:    rsp_bus_byte = CMD_FUNCTION_SET;
               2'd1:    rsp_bus_byte = CMD_DISPLAY_ON;
               2'd2:    rsp_bus_byte = CMD_ENTRY_MODE;
               default: rsp_bus_byte = CMD_CLEAR;
            endcase
            rsp_last = (step_ff == STEP_W'(INIT_WRITES - 1));
         end
         ACT_CHAR: begin
            rsp_is_data  = (step_ff != '0);
            rsp_bus_byte = (step_ff == '0) ? cursor : char_ff;
            rsp_last     = (step_ff != '0);
         end
         ACT_NUMBER: begin
            rsp_is_data  = (step_ff != '0);
            rsp_bus_byte = (step_ff == '0) ? cursor : (ASCII_ZERO | {4'b0000, digit});
            rsp_last     = (step_ff == count_ff);
         end
         default: begin
            rsp_is_data  = 1'b0;
            rsp_bus_byte = 8'h00;
            rsp_last     = 1'b0;
         end
      endcase
   end

   assign status.last = rsp_last;

endmodule

`default_nettype wire

// ===== hdl/char_lcd_write_sequencer.sv =====
// character lcd write sequencer, 8-bit bus
// req_ channel: one display request per item (init, show character, show number).
// rsp_ channel: one item per bus write; rsp_is_data is the register select, rsp_bus_byte
// the byte, rsp_last marks the final write of the request.
// init gives four command writes, show character gives cursor command then the character,
// show number gives cursor command then digit_count ascii digits (at most 16), most significant first.
// a request with action code 3 is dropped and gives no write.
// writes start the cycle after the request is taken for init and character; a number
// first runs a binary-to-bcd conversion (one bit per cycle). writes then go out one
// per cycle while the receiver takes them at once, and the controller returns to idle
// after the last write before the next request is taken.
// one request is in flight at a time; req_ready is high only while no writes are pending.
// when the receiver stalls, rsp_valid and the payload hold until the write is taken.
// synchronous reset returns the controller to idle and drops any pending writes.
`default_nettype none

module char_lcd_write_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [1:0]  req_line,
   input  wire logic [4:0]  req_column,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [15:0] req_number,
   input  wire logic [4:0]  req_digit_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_is_data,
   output logic [7:0]       rsp_bus_byte,
   output logic             rsp_last
);
   import lcdws_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   lcdws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   lcdws_dp u_dp (
      .clock           (clock),
      .cmd             (cmd),
      .status          (status),
      .req_action      (req_action),
      .req_line        (req_line),
      .req_column      (req_column),
      .req_char_code   (req_char_code),
      .req_number      (req_number),
      .req_digit_count (req_digit_count),
      .rsp_is_data     (rsp_is_data),
      .rsp_bus_byte    (rsp_bus_byte),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lcdws_pkg::*;

   typedef struct packed {
      logic       is_data;
      logic [7:0] bus_byte;
      logic       last;
   } bus_write_type;

   typedef struct {
      action_type  action;
      logic [1:0]  row;
      logic [4:0]  column;
      logic [7:0]  char_code;
      logic [15:0] number;
      logic [4:0]  digit_count;
   } lcd_request_type;

   localparam int RANDOM_REQUESTS = 340;
   localparam int PHASE1_AT       = 120;
   localparam int PHASE2_AT       = 240;
   localparam int DRAIN_AT        = 200;
   localparam int LONG_HOLD_AT    = 300;
   localparam int LONG_HOLD_LEN   = 150;
   localparam int TAIL_CYCLES     = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = '0;
   logic [1:0]  req_line = '0;
   logic [4:0]  req_column = '0;
   logic [7:0]  req_char_code = '0;
   logic [15:0] req_number = '0;
   logic [4:0]  req_digit_count = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_is_data;
   logic [7:0]  rsp_bus_byte;
   logic        rsp_last;

   lcd_request_type pending_requests[$];
   bus_write_type   expected_writes[$];

   int   idle_phase = 0;
   logic long_hold_req = 1'b0;
   logic long_hold_done = 1'b0;
   int   hold_cycles = 0;
   int   accepted_items = 0;
   logic draining = 1'b0;
   logic drain_done = 1'b0;
   logic failed = 1'b0;

   char_lcd_write_sequencer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_line        (req_line),
      .req_column      (req_column),
      .req_char_code   (req_char_code),
      .req_number      (req_number),
      .req_digit_count (req_digit_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_data     (rsp_is_data),
      .rsp_bus_byte    (rsp_bus_byte),
      .rsp_last        (rsp_last)
   );

   always #1 clock = ~clock;

   task automatic push_write(input logic is_data, input logic [7:0] bus_byte);
      bus_write_type w;
      w.is_data  = is_data;
      w.bus_byte = bus_byte;
      w.last     = 1'b0;
      expected_writes.push_back(w);
   endtask

   // expected bus writes for one accepted request
   task automatic predict_bus_writes(input lcd_request_type r);
      logic [7:0]    cursor;
      bus_write_type tail;
      int            count;
      int            scale;
      int            d;
      cursor = {3'b000, r.column} - 8'd1;
      if (r.row != TOP_LINE) begin
         cursor = cursor + LINE2_OFFSET;
      end
      cursor = CMD_SET_DDRAM | cursor;
      case (r.action)
         ACT_INIT: begin
            push_write(1'b0, CMD_FUNCTION_SET);
            push_write(1'b0, CMD_DISPLAY_ON);
            push_write(1'b0, CMD_ENTRY_MODE);
            push_write(1'b0, CMD_CLEAR);
         end
         ACT_CHAR: begin
            push_write(1'b0, cursor);
            push_write(1'b1, r.char_code);
         end
         ACT_NUMBER: begin
            count = (int'(r.digit_count) > MAX_DIGITS) ? MAX_DIGITS : int'(r.digit_count);
            push_write(1'b0, cursor);
            for (int e = count - 1; e >= 0; e--) begin
               d = 0;
               // weights of 10^5 and up are always zero for a 16-bit value
               if (e < 5) begin
                  scale = 1;
                  repeat (e) scale = scale * 10;
                  d = (int'(r.number) / scale) % 10;
               end
               push_write(1'b1, ASCII_ZERO + 8'(d));
            end
         end
         default: return;
      endcase
      tail = expected_writes.pop_back();
      tail.last = 1'b1;
      expected_writes.push_back(tail);
   endtask

   function automatic lcd_request_type make_request(input int action, input int row,
                                                    input int column, input int char_code,
                                                    input int number, input int digit_count);
      lcd_request_type r;
      r.action      = action_type'(2'(action));
      r.row         = 2'(row);
      r.column      = 5'(column);
      r.char_code   = 8'(char_code);
      r.number      = 16'(number);
      r.digit_count = 5'(digit_count);
      return r;
   endfunction

   function automatic lcd_request_type random_request();
      lcd_request_type r;
      int              pick;
      pick = $urandom_range(99);
      if (pick < 10) r.action = ACT_INIT;
      else if (pick < 45) r.action = ACT_CHAR;
      else if (pick < 95) r.action = ACT_NUMBER;
      else r.action = ACT_NONE;
      r.row = ($urandom_range(9) < 8) ? 2'($urandom_range(1, 2)) : 2'($urandom_range(3));
      r.column = ($urandom_range(9) < 8) ? 5'($urandom_range(1, 16)) : 5'($urandom_range(31));
      r.char_code = 8'($urandom_range(255));
      pick = $urandom_range(9);
      if (pick < 5) r.number = 16'($urandom_range(65535));
      else if (pick < 7) r.number = 16'($urandom_range(99));
      else if (pick < 8) r.number = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
      else r.number = 16'($urandom_range(65535, 60000));
      pick = $urandom_range(9);
      if (pick < 7) r.digit_count = 5'($urandom_range(6));
      else if (pick < 9) r.digit_count = 5'($urandom_range(16, 7));
      else r.digit_count = 5'($urandom_range(31, 17));
      return r;
   endfunction

   function automatic int sender_idle_pct(input int phase);
      return (phase == 0) ? 34 : (phase == 1) ? 73 : 0;
   endfunction

   function automatic int receiver_idle_pct(input int phase);
      return (phase == 0) ? 73 : (phase == 1) ? 34 : 0;
   endfunction

   // request driver
   always @(posedge clock) begin : request_driver
      lcd_request_type head;
      logic            took;
      logic            offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = req_valid && req_ready;
         if (took) begin
            predict_bus_writes(pending_requests.pop_front());
            accepted_items = accepted_items + 1;
            idle_phase <= (accepted_items < PHASE1_AT) ? 0 :
                          (accepted_items < PHASE2_AT) ? 1 : 2;
            if (accepted_items == LONG_HOLD_AT) begin
               long_hold_req <= 1'b1;
            end
            if (accepted_items == DRAIN_AT && !drain_done) begin
               draining = 1'b1;
            end
         end
         // pause the sender until every write has come back
         if (draining && expected_writes.size() == 0 && !rsp_valid) begin
            draining   = 1'b0;
            drain_done = 1'b1;
         end
         if (!(req_valid && !took)) begin
            offer = pending_requests.size() != 0 && !draining &&
                    ($urandom_range(99) >= sender_idle_pct(idle_phase));
            if (offer) begin
               head = pending_requests[0];
               req_valid       <= 1'b1;
               req_action      <= head.action;
               req_line        <= head.row;
               req_column      <= head.column;
               req_char_code   <= head.char_code;
               req_number      <= head.number;
               req_digit_count <= head.digit_count;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
         hold_cycles    <= LONG_HOLD_LEN;
         long_hold_done <= 1'b1;
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct(idle_phase));
      end
   end

   // write monitor
   always @(posedge clock) begin : write_monitor
      bus_write_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_writes.size() == 0) begin
            $display("%0t: unexpected write is_data=%0b byte=%02h last=%0b",
                     $time, rsp_is_data, rsp_bus_byte, rsp_last);
            failed = 1'b1;
         end else begin
            want = expected_writes.pop_front();
            if (rsp_is_data !== want.is_data) begin
               $display("%0t: is_data expected %0b actual %0b",
                        $time, want.is_data, rsp_is_data);
               failed = 1'b1;
            end
            if (rsp_bus_byte !== want.bus_byte) begin
               $display("%0t: bus_byte expected %02h actual %02h",
                        $time, want.bus_byte, rsp_bus_byte);
               failed = 1'b1;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %0b actual %0b",
                        $time, want.last, rsp_last);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      int              counted;
      lcd_request_type r;
      logic            missing;
      // directed: init, both lines, column extremes, digit count extremes, dropped action
      pending_requests.push_back(make_request(ACT_INIT, 1, 1, 0, 0, 0));
      pending_requests.push_back(make_request(ACT_CHAR, 1, 1, 8'h00, 0, 0));
      pending_requests.push_back(make_request(ACT_CHAR, 2, 16, 8'hFF, 0, 0));
      pending_requests.push_back(make_request(ACT_CHAR, 1, 0, 8'h41, 0, 0));
      pending_requests.push_back(make_request(ACT_CHAR, 2, 0, 8'h5A, 0, 0));
      pending_requests.push_back(make_request(ACT_CHAR, 0, 31, 8'hAA, 0, 0));
      pending_requests.push_back(make_request(ACT_CHAR, 3, 17, 8'h55, 0, 0));
      pending_requests.push_back(make_request(ACT_NUMBER, 1, 1, 0, 0, 0));
      pending_requests.push_back(make_request(ACT_NUMBER, 2, 5, 0, 65535, 0));
      pending_requests.push_back(make_request(ACT_NUMBER, 1, 3, 0, 65535, 5));
      pending_requests.push_back(make_request(ACT_NUMBER, 2, 16, 0, 12345, 3));
      pending_requests.push_back(make_request(ACT_NUMBER, 1, 1, 0, 9, 1));
      pending_requests.push_back(make_request(ACT_NUMBER, 2, 1, 0, 65535, 6));
      pending_requests.push_back(make_request(ACT_NUMBER, 1, 8, 0, 54321, 16));
      pending_requests.push_back(make_request(ACT_NUMBER, 2, 8, 0, 40000, 17));
      pending_requests.push_back(make_request(ACT_NUMBER, 0, 0, 0, 0, 31));
      pending_requests.push_back(make_request(ACT_NONE, 1, 1, 8'h33, 100, 3));
      pending_requests.push_back(make_request(ACT_INIT, 3, 31, 8'hFF, 65535, 31));
      pending_requests.push_back(make_request(ACT_NONE, 2, 31, 8'hFF, 65535, 31));
      pending_requests.push_back(make_request(ACT_CHAR, 1, 16, 8'h7F, 0, 0));
      pending_requests.push_back(make_request(ACT_NUMBER, 3, 15, 0, 32768, 2));
      pending_requests.push_back(make_request(ACT_NUMBER, 1, 10, 0, 21845, 10));
      counted = 0;
      while (counted < RANDOM_REQUESTS) begin
         r = random_request();
         pending_requests.push_back(r);
         if (r.action != ACT_NONE) counted++;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (pending_requests.size() != 0 || req_valid);
      do @(posedge clock); while (expected_writes.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      missing = (expected_writes.size() != 0);
      if (missing) begin
         $display("%0t: %0d expected writes never arrived", $time, expected_writes.size());
      end
      if (!failed && !missing) begin
         $display("[char_lcd_write_sequencer] OK");
      end else begin
         $display("[char_lcd_write_sequencer] ERROR");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("%0t: timeout", $time);
      $display("[char_lcd_write_sequencer] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
